// ----- hw/rtl/lvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lvc_pkg
// shared types and codes for the lru vertex cache simulator
// ----------------------------------------------------------------------------
package lvc_pkg;

	localparam int DEF_CACHE_DEPTH = 32;
	localparam int VTX_W           = 32;
	localparam int SLOT_W          = 5;
	localparam int CMD_W           = 2;

	localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [VTX_W-1:0]  vertex_index;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] hit_position;
		logic [VTX_W-1:0]  miss_total;
		logic [VTX_W-1:0]  slot_vertex;
		logic              slot_valid;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic compare;
		logic commit;
	} ctl_t;

endpackage

// ----- hw/rtl/lvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lvc_ctrl
// sequencer: load, compare stage for accesses, then commit
// ----------------------------------------------------------------------------
module lvc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lvc_pkg::CMD_W-1:0]  command,
	output logic                       busy,
	output lvc_pkg::ctl_t              ctl
);
	import lvc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		ctl.load    = 1'b0;
		ctl.compare = 1'b0;
		ctl.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = (command == CMD_ACCESS) ? ST_MATCH : ST_APPLY;
				end
			end
			ST_MATCH: begin
				ctl.compare = 1'b1;
				state_d     = ST_APPLY;
			end
			ST_APPLY: begin
				ctl.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.compare, ctl.commit}))
		else $error("more than one datapath command at once");

	a_apply_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> !busy)
		else $error("controller did not return to idle after commit");

	a_match_then_apply: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.compare |=> ctl.commit)
		else $error("compare stage not followed by commit");

endmodule

// ----- hw/rtl/lvc_datapath.sv -----
// ----------------------------------------------------------------------------
// lvc_datapath
// move-to-front stack, registered match vector, miss counter, result register
// ----------------------------------------------------------------------------
module lvc_datapath #(
	parameter int CACHE_DEPTH = lvc_pkg::DEF_CACHE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lvc_pkg::ctl_t  ctl,
	input  lvc_pkg::req_t  req,
	output logic           done,
	output lvc_pkg::rsp_t  rsp
);
	import lvc_pkg::*;

	localparam int IW = $clog2(CACHE_DEPTH);
	localparam int SW = 7;

	req_t                   req_q;
	logic [VTX_W-1:0]       entry_q [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] valid_q;
	logic [CACHE_DEPTH-1:0] match_q;
	logic [VTX_W-1:0]       miss_q;
	rsp_t                   rsp_q;
	logic                   done_q;

	logic [CACHE_DEPTH-1:0] match_d;
	logic [CACHE_DEPTH-1:0] lowest;
	logic [CACHE_DEPTH-1:0] shift_en;
	logic [IW-1:0]          hit_pos;
	logic                   any_hit;
	logic [VTX_W-1:0]       miss_next;
	logic [SW-1:0]          slot_wide;
	logic                   slot_in_range;
	logic [IW-1:0]          slot_idx;
	rsp_t                   rsp_d;

	// parallel compare against every valid entry
	always_comb begin
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			match_d[i] = valid_q[i] && (entry_q[i] == req_q.vertex_index);
		end
	end

	// isolate lowest match; entries at or above it move down, all on a miss
	assign lowest   = match_q & (~match_q + CACHE_DEPTH'(1));
	assign shift_en = lowest | (lowest - CACHE_DEPTH'(1));
	assign any_hit  = |match_q;

	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			if (lowest[i]) begin
				hit_pos = hit_pos | IW'(i);
			end
		end
	end

	assign miss_next = (!any_hit && (miss_q != '1)) ? miss_q + VTX_W'(1) : miss_q;

	assign slot_wide     = SW'(req_q.slot);
	assign slot_in_range = slot_wide < SW'(CACHE_DEPTH);
	assign slot_idx      = slot_wide[IW-1:0];

	always_comb begin
		rsp_d            = '0;
		rsp_d.miss_total = miss_q;
		unique case (req_q.command)
			CMD_ACCESS: begin
				rsp_d.hit          = any_hit;
				rsp_d.hit_position = SLOT_W'(hit_pos);
				rsp_d.miss_total   = miss_next;
			end
			CMD_CLEAR: begin
				rsp_d.miss_total = '0;
			end
			CMD_READ: begin
				if (slot_in_range && valid_q[slot_idx]) begin
					rsp_d.slot_vertex = entry_q[slot_idx];
					rsp_d.slot_valid  = 1'b1;
				end
			end
			default: begin
				rsp_d.miss_total = miss_q;
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.compare) begin
			match_q <= match_d;
		end
		if (ctl.commit) begin
			rsp_q <= rsp_d;
			if (req_q.command == CMD_ACCESS) begin
				entry_q[0] <= req_q.vertex_index;
				for (int i = 1; i < CACHE_DEPTH; i++) begin
					if (shift_en[i]) begin
						entry_q[i] <= entry_q[i-1];
					end
				end
			end
		end
	end

	// control state: valid bits, miss count, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			miss_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.commit;
			if (ctl.commit) begin
				unique case (req_q.command)
					CMD_ACCESS: begin
						miss_q     <= miss_next;
						valid_q[0] <= 1'b1;
						for (int i = 1; i < CACHE_DEPTH; i++) begin
							if (shift_en[i]) begin
								valid_q[i] <= valid_q[i-1];
							end
						end
					end
					CMD_CLEAR: begin
						valid_q <= '0;
						miss_q  <= '0;
					end
					default: begin
						miss_q <= miss_q;
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_access_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && req_q.command == CMD_ACCESS) |=> valid_q[0])
		else $error("top entry not valid after access");

	a_hit_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.hit) |-> !rsp_q.slot_valid)
		else $error("access result carries slot data");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && req_q.command == CMD_ACCESS && any_hit) |=> (miss_q == $past(miss_q)))
		else $error("miss count changed on a hit");

endmodule

// ----- hw/rtl/lru_vertex_cache_simulator.sv -----
// ----------------------------------------------------------------------------
// lru_vertex_cache_simulator
// move-to-front lru vertex cache model with hit reporting and miss count
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken at a rising edge with start high and busy low;
//   req carries command (access, clear, read), vertex_index and slot.
//   every transaction returns one result on rsp, marked by done for exactly
//   one cycle; the receiver cannot stall, so it must take rsp while done.
// timing:
//   access: the request is registered at the take edge, the parallel compare
//   of all entries is registered in the match state, and the apply state picks
//   the lowest match and shifts the stack; done follows in the next cycle.
//   clear and read skip the compare stage and go straight to apply. a new
//   transaction is taken only once busy has dropped, after the last one ends.
// reset:
//   arst_n empties the stack (all valid bits cleared), zeroes the miss count
//   and drops done; no clearing pass is needed, the block is ready at once.
// ----------------------------------------------------------------------------
module lru_vertex_cache_simulator #(
	parameter int CACHE_DEPTH = lvc_pkg::DEF_CACHE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lvc_pkg::req_t  req,
	output logic           done,
	output lvc_pkg::rsp_t  rsp
);
	import lvc_pkg::*;

	// command bundle from sequencer to datapath
	ctl_t ctl;

	// sequencer: idle, compare (accesses only), commit
	lvc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (req.command),
		.busy    (busy),
		.ctl     (ctl)
	);

	// stack, match vector, miss counter and result register
	lvc_datapath #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// result only ever shows while idle, so a transaction never overlaps it
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a taken transaction makes the block busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction taken but block not busy");

	// a taken access yields its result once it has passed the compare and commit states
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.command == CMD_ACCESS) |-> ##3 done)
		else $error("access result missing");

endmodule
